// ===== rtl/core/tbcf_pkg.sv =====
// Package of the taxel baseline compressor and framer.
// Holds the sizes, codes and the store request type used by the core, its baseline store and the testbench.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbcf_pkg;

    localparam int TRIANGLES = 16;
    localparam int TAXELS    = 12;
    localparam int DEPTH     = TRIANGLES * TAXELS;
    localparam int IDX_W     = $clog2(DEPTH);

    localparam int RAW_W  = 16;
    localparam int ID_W   = 10;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 4;

    // Configuration register indexes.
    localparam logic CFG_BOARD_ADDRESS = 1'b0;
    localparam logic CFG_TAXEL_MODE    = 1'b1;

    // Taxel mode codes.
    localparam logic [1:0] MODE_TWELVE = 2'd0;
    localparam logic [1:0] MODE_THREE  = 2'd1;
    localparam logic [1:0] MODE_ONE    = 2'd2;

    // Operation codes.
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h40;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hC0;
    localparam logic [ID_W-1:0]   ID_BASE    = 10'h300;

    localparam logic [BYTE_W-1:0] BYTE_CENTRE  = 8'd244;
    localparam logic [BYTE_W-1:0] BYTE_MAX     = 8'd255;
    localparam logic [BYTE_W-1:0] BYTE_MIN     = 8'd1;
    localparam logic [13:0]       D_ABOVE_SAT  = 14'd10;
    localparam logic [13:0]       D_BELOW_SAT  = 14'd243;

    // Request from the pipeline to the baseline store.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic [RAW_W-1:0] wdata;
    } tbcf_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/tbcf_baseline_mem.sv =====
// Baseline store: one 16-bit baseline per taxel, in a memory with registered read.
// Per-entry valid bits make an entry never calibrated read as zero. Uses tbcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbcf_baseline_mem (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tbcf_pkg::tbcf_mem_req_t req,
    output logic [tbcf_pkg::RAW_W-1:0] rd_data
);
    import tbcf_pkg::*;

    logic [RAW_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [RAW_W-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end else begin
            if (req.wr_en) begin
                written_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_hit_reg <= written_reg[req.addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/taxel_baseline_compress_framer_core.sv =====
// Top level of the taxel baseline compressor and framer.
// Four-stage pipeline around tbcf_baseline_mem; uses tbcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one taxel reading per word and returns framed payload bytes. A calibrate word stores
// its reading as the baseline of its taxel and gives no output; a measure word gives one
// compressed byte, preceded by a header byte when it opens a frame. Words for taxels outside
// the store, and measure words for taxels outside the active mode, are dropped. Words move
// through four register stages (decode, baseline read, compression, output with a one-byte
// holding register), so a new word can be taken in every cycle while the output is not held
// by back-pressure or by a pending value byte behind a header. The store needs no clearing
// pass after reset. Configuration writes are always accepted and must only be made while
// the core is empty.
module taxel_baseline_compress_framer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // triangle[3:0], taxel[7:4], raw_reading[23:8]
    input  wire logic [0:0]  s_tuser,   // operation[0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // frame_id[9:0], byte_value[17:10],
                                        // frame_length[21:18], run_last[22], zero[23]
    output logic             m_tlast    // frame_end
);
    import tbcf_pkg::*;

    // Configuration.
    logic [3:0] board_address_reg;
    logic [1:0] taxel_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_address_reg <= 4'd15;
            taxel_mode_reg    <= MODE_TWELVE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BOARD_ADDRESS: board_address_reg <= cfg_data;
                CFG_TAXEL_MODE:    taxel_mode_reg    <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // Input fields.
    logic             in_op;
    logic [3:0]       in_tri;
    logic [3:0]       in_tax;
    logic [RAW_W-1:0] in_raw;

    assign in_op  = s_tuser[0];
    assign in_tri = s_tdata[3:0];
    assign in_tax = s_tdata[7:4];
    assign in_raw = s_tdata[23:8];

    // Stage 1: decode.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_cal_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [RAW_W-1:0] s1_raw_reg;
    logic [ID_W-1:0]  s1_id_reg;
    logic             s1_hdr_reg;
    logic             s1_hdr_second_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_fend_reg;

    logic [3:0]       active;
    logic             in_keep;
    logic             dec_hdr;
    logic             dec_hdr_second;
    logic [LEN_W-1:0] dec_len;
    logic             dec_fend;

    always_comb begin
        active         = 4'd0;
        dec_hdr        = 1'b0;
        dec_hdr_second = 1'b0;
        dec_len        = 4'd2;
        dec_fend       = 1'b1;
        case (taxel_mode_reg)
            MODE_TWELVE: begin
                active = 4'd12;
                if (in_tax < 4'd7) begin
                    dec_len  = 4'd8;
                    dec_fend = (in_tax == 4'd6);
                    dec_hdr  = (in_tax == 4'd0);
                end else begin
                    dec_len        = 4'd6;
                    dec_fend       = (in_tax == 4'd11);
                    dec_hdr        = (in_tax == 4'd7);
                    dec_hdr_second = 1'b1;
                end
            end
            MODE_THREE: begin
                active   = 4'd3;
                dec_len  = 4'd4;
                dec_fend = (in_tax == 4'd2);
                dec_hdr  = (in_tax == 4'd0);
            end
            MODE_ONE: begin
                active  = 4'd1;
                dec_hdr = 1'b1;
            end
            default: active = 4'd0;
        endcase
        in_keep = (int'(in_tri) < TRIANGLES) && (int'(in_tax) < TAXELS)
                  && ((in_op == OP_CALIBRATE) || (in_tax < active));
    end

    logic s1_go;
    logic s2_ready;
    logic s_acc;

    assign s1_go    = s1_valid_reg && (s1_cal_reg || s2_ready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_tready) begin
            s1_valid_next = s_acc && in_keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_cal_reg        <= (in_op == OP_CALIBRATE);
            s1_idx_reg        <= IDX_W'(int'(in_tri) * TAXELS + int'(in_tax));
            s1_raw_reg        <= in_raw;
            s1_id_reg         <= ID_BASE | {2'b00, board_address_reg, in_tri};
            s1_hdr_reg        <= dec_hdr;
            s1_hdr_second_reg <= dec_hdr_second;
            s1_len_reg        <= dec_len;
            s1_fend_reg       <= dec_fend;
        end
    end

    // Stage 2: baseline write or read.
    tbcf_mem_req_t    mem_req;
    logic [RAW_W-1:0] base;

    assign mem_req.wr_en = s1_go && s1_cal_reg;
    assign mem_req.rd_en = s1_go && !s1_cal_reg;
    assign mem_req.addr  = s1_idx_reg;
    assign mem_req.wdata = s1_raw_reg;

    tbcf_baseline_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (base)
    );

    logic             s2_valid_reg;
    logic [RAW_W-1:0] s2_raw_reg;
    logic [ID_W-1:0]  s2_id_reg;
    logic             s2_hdr_reg;
    logic             s2_hdr_second_reg;
    logic [LEN_W-1:0] s2_len_reg;
    logic             s2_fend_reg;
    logic             s3_ready;

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= mem_req.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.rd_en) begin
            s2_raw_reg        <= s1_raw_reg;
            s2_id_reg         <= s1_id_reg;
            s2_hdr_reg        <= s1_hdr_reg;
            s2_hdr_second_reg <= s1_hdr_second_reg;
            s2_len_reg        <= s1_len_reg;
            s2_fend_reg       <= s1_fend_reg;
        end
    end

    // Stage 3: compression against the baseline.
    logic [RAW_W:0]    diff_up;
    logic [RAW_W-1:0]  diff_dn;
    logic [13:0]       delta;
    logic              at_or_above;
    logic [BYTE_W-1:0] comp_byte;

    always_comb begin
        diff_up     = {1'b0, base} - {1'b0, s2_raw_reg};
        diff_dn     = s2_raw_reg - base;
        at_or_above = !diff_up[RAW_W];
        delta       = at_or_above ? diff_up[RAW_W-1:2] : diff_dn[RAW_W-1:2];
        if (at_or_above) begin
            comp_byte = (delta >= D_ABOVE_SAT) ? BYTE_MAX : BYTE_CENTRE + delta[7:0];
        end else begin
            comp_byte = (delta >= D_BELOW_SAT) ? BYTE_MIN : BYTE_CENTRE - delta[7:0];
        end
    end

    logic              s3_valid_reg;
    logic [BYTE_W-1:0] s3_byte_reg;
    logic [ID_W-1:0]   s3_id_reg;
    logic              s3_hdr_reg;
    logic              s3_hdr_second_reg;
    logic [LEN_W-1:0]  s3_len_reg;
    logic              s3_fend_reg;
    logic              out_take;
    logic              s2_go;

    assign s3_ready = !s3_valid_reg || out_take;
    assign s2_go    = s2_valid_reg && s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go) begin
            s3_byte_reg       <= comp_byte;
            s3_id_reg         <= s2_id_reg;
            s3_hdr_reg        <= s2_hdr_reg;
            s3_hdr_second_reg <= s2_hdr_second_reg;
            s3_len_reg        <= s2_len_reg;
            s3_fend_reg       <= s2_fend_reg;
        end
    end

    // Stage 4: output register. A word that opens a frame shows its header first and
    // parks the value byte in the holding register until the header is taken.
    logic              out_valid_reg;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_fend_reg;
    logic              out_last_reg;
    logic [BYTE_W-1:0] pend_byte_reg;
    logic              pend_fend_reg;
    logic              out_hs;
    logic              load;

    assign out_hs   = out_valid_reg && m_tready;
    assign out_take = !out_valid_reg || (m_tready && !pend_valid_reg);
    assign load     = s3_valid_reg && out_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= s3_hdr_reg;
        end else if (out_hs) begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_id_reg    <= s3_id_reg;
            out_len_reg   <= s3_len_reg;
            pend_byte_reg <= s3_byte_reg;
            pend_fend_reg <= s3_fend_reg;
            if (s3_hdr_reg) begin
                out_byte_reg <= s3_hdr_second_reg ? HDR_SECOND : HDR_FIRST;
                out_fend_reg <= 1'b0;
                out_last_reg <= 1'b0;
            end else begin
                out_byte_reg <= s3_byte_reg;
                out_fend_reg <= s3_fend_reg;
                out_last_reg <= 1'b1;
            end
        end else if (out_hs && pend_valid_reg) begin
            out_byte_reg <= pend_byte_reg;
            out_fend_reg <= pend_fend_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_last_reg, out_len_reg, out_byte_reg, out_id_reg};
    assign m_tlast  = out_fend_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tbcf_checker.sv =====
// Port-level checks on the taxel baseline compressor and framer result stream.
// Bound to taxel_baseline_compress_framer_core; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module tbcf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled word stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // A header byte is one of the two header codes and never ends a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[22] |->
            (m_tdata[17:10] == 8'h40 || m_tdata[17:10] == 8'hC0) && !m_tlast)
        else $error("bad header word");

    // The value byte follows its header at once, in the same frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tdata[22] |=>
            m_tvalid && m_tdata[22] && m_tdata[9:0] == $past(m_tdata[9:0])
            && m_tdata[21:18] == $past(m_tdata[21:18]))
        else $error("value word did not follow its header");

    // Identifiers always carry the fixed upper bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:8] == 2'b11 && !m_tdata[23])
        else $error("malformed frame identifier");

endmodule

bind taxel_baseline_compress_framer_core tbcf_checker u_tbcf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/taxel_baseline_compress_framer_core_test.sv =====
// Self-checking testbench of taxel_baseline_compress_framer_core.
// Drives reading words and register writes, predicts the framed payload bytes and checks
// each output word; depends on tbcf_pkg and the core only.
`timescale 1ns / 1ps

module taxel_baseline_compress_framer_core_test;
    import tbcf_pkg::*;

    localparam logic [1:0] MODE_UNDEF    = 2'd3;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         SEGMENTS      = 12;

    typedef struct packed {
        logic       op;
        logic [3:0] triangle;
        logic [3:0] taxel;
        logic [15:0] raw;
    } reading_t;

    typedef struct packed {
        logic [9:0] frame_id;
        logic [7:0] byte_value;
        logic [3:0] frame_length;
        logic       frame_end;
        logic       run_last;
    } frame_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [3:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tlast;

    taxel_baseline_compress_framer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Predictor state: its own copy of the baselines and the registers.
    logic [15:0] model_baseline [DEPTH];
    logic [3:0]  model_address = 4'd15;
    logic [1:0]  model_mode    = MODE_TWELVE;
    frame_byte_t expected_bytes [$];

    // Stimulus side: words waiting for the driver, and a shadow of the baselines so that
    // measure readings can be placed near them.
    reading_t    pending_words [$];
    logic [15:0] gen_baseline [DEPTH];
    logic [1:0]  gen_mode = MODE_TWELVE;
    int          gen_effective = 0;

    int   sender_idle_pct   = 0;
    int   receiver_idle_pct = 0;
    logic s_word_taken      = 1'b0;
    int   words_queued      = 0;
    int   words_accepted    = 0;
    int   bytes_out         = 0;
    int   header_count      = 0;
    int   settings_count    = 0;
    int   mismatches        = 0;
    int   stall_cycles      = 0;

    function automatic int active_taxels(input logic [1:0] mode);
        int n;
        case (mode)
            MODE_TWELVE: n = 12;
            MODE_THREE:  n = 3;
            MODE_ONE:    n = 1;
            default:     n = 0;
        endcase
        if (n > TAXELS) n = TAXELS;
        return n;
    endfunction

    function automatic logic [7:0] compress_reading(input logic [15:0] base,
                                                    input logic [15:0] raw);
        logic [15:0] diff;
        logic [13:0] steps;
        if (base >= raw) begin
            diff  = base - raw;
            steps = diff[15:2];
            if (steps >= D_ABOVE_SAT) return BYTE_MAX;
            return BYTE_CENTRE + steps[7:0];
        end
        diff  = raw - base;
        steps = diff[15:2];
        if (steps >= D_BELOW_SAT) return BYTE_MIN;
        return BYTE_CENTRE - steps[7:0];
    endfunction

    task automatic predict_frame_bytes(input reading_t w);
        int          slot;
        logic [3:0]  len;
        logic        fend;
        logic        has_hdr;
        logic [7:0]  hdr;
        logic [9:0]  id;
        if (int'(w.triangle) >= TRIANGLES || int'(w.taxel) >= TAXELS) return;
        slot = int'(w.triangle) * TAXELS + int'(w.taxel);
        if (w.op == OP_CALIBRATE) begin
            model_baseline[slot] = w.raw;
            return;
        end
        if (int'(w.taxel) >= active_taxels(model_mode)) return;
        has_hdr = 1'b0;
        hdr     = HDR_FIRST;
        case (model_mode)
            MODE_TWELVE: begin
                if (w.taxel < 4'd7) begin
                    len     = 4'd8;
                    fend    = (w.taxel == 4'd6);
                    has_hdr = (w.taxel == 4'd0);
                end else begin
                    len     = 4'd6;
                    fend    = (w.taxel == 4'd11);
                    has_hdr = (w.taxel == 4'd7);
                    hdr     = HDR_SECOND;
                end
            end
            MODE_THREE: begin
                len     = 4'd4;
                fend    = (w.taxel == 4'd2);
                has_hdr = (w.taxel == 4'd0);
            end
            default: begin
                len     = 4'd2;
                fend    = 1'b1;
                has_hdr = 1'b1;
            end
        endcase
        id = ID_BASE | {6'd0, w.triangle} | {2'd0, model_address, 4'd0};
        if (has_hdr) expected_bytes.push_back('{id, hdr, len, 1'b0, 1'b0});
        expected_bytes.push_back('{id, compress_reading(model_baseline[slot], w.raw), len,
                                   fend, 1'b1});
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at %0t ns, output byte %0d: %s is 0x%0h, expected 0x%0h",
                     $time, bytes_out, what, got, want);
    endtask

    // Input driver: a word stays on the bus until it has been taken.
    always @(negedge aclk) begin
        reading_t w;
        if (s_tvalid && !s_word_taken) begin
            // hold the current word
        end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
        begin
            w = pending_words.pop_front();
            s_tdata  <= {w.raw, w.taxel, w.triangle};
            s_tuser  <= w.op;
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Monitor: updates the predictor on every accepted word and checks every output word.
    always @(posedge aclk) begin
        reading_t    w;
        frame_byte_t got;
        frame_byte_t want;
        logic        moved;
        if (!aresetn) begin
            s_word_taken = 1'b0;
        end else begin
            moved        = 1'b0;
            s_word_taken = s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                if (cfg_index == CFG_BOARD_ADDRESS) model_address = cfg_data;
                else model_mode = cfg_data[1:0];
            end
            if (s_word_taken) begin
                moved      = 1'b1;
                w.op       = s_tuser[0];
                w.triangle = s_tdata[3:0];
                w.taxel    = s_tdata[7:4];
                w.raw      = s_tdata[23:8];
                predict_frame_bytes(w);
                words_accepted++;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got   = '{m_tdata[9:0], m_tdata[17:10], m_tdata[21:18], m_tlast, m_tdata[22]};
                if (expected_bytes.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (!want.run_last) header_count++;
                    if (got.frame_id !== want.frame_id)
                        report_mismatch("frame_id", got.frame_id, want.frame_id);
                    if (got.byte_value !== want.byte_value)
                        report_mismatch("byte_value", got.byte_value, want.byte_value);
                    if (got.frame_length !== want.frame_length)
                        report_mismatch("frame_length", got.frame_length, want.frame_length);
                    if (got.frame_end !== want.frame_end)
                        report_mismatch("frame_end", got.frame_end, want.frame_end);
                    if (got.run_last !== want.run_last)
                        report_mismatch("run_last", got.run_last, want.run_last);
                end
                bytes_out++;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles, %0d bytes still expected",
                         stall_cycles, expected_bytes.size());
                $display("taxel_baseline_compress_framer_core_test NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_reading(input logic op, input logic [3:0] tri_no,
                                 input logic [3:0] tax_no, input logic [15:0] raw);
        reading_t w;
        w = '{op, tri_no, tax_no, raw};
        pending_words.push_back(w);
        words_queued++;
        if (int'(tax_no) < TAXELS) begin
            if (op == OP_CALIBRATE) begin
                gen_baseline[int'(tri_no) * TAXELS + int'(tax_no)] = raw;
                gen_effective++;
            end else if (int'(tax_no) < active_taxels(gen_mode)) begin
                gen_effective++;
            end
        end
    endtask

    // Mostly just around the baseline, reaching a little past both saturation points.
    function automatic logic [15:0] near_raw(input logic [3:0] tri_no, input logic [3:0] tax_no);
        if (int'(tax_no) >= TAXELS || $urandom_range(0, 9) == 0) return 16'($urandom);
        return gen_baseline[int'(tri_no) * TAXELS + int'(tax_no)]
               + 16'($urandom_range(0, 1060)) - 16'd60;
    endfunction

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [3:0] addr, input logic [1:0] mode);
        wait_idle();
        write_reg(CFG_BOARD_ADDRESS, addr);
        write_reg(CFG_TAXEL_MODE, {2'd0, mode});
        gen_mode = mode;
        settings_count++;
    endtask

    task automatic run_random_segment(input int seg);
        logic [1:0] mode_cycle [4];
        logic [1:0] mode;
        logic [3:0] addr;
        logic [3:0] tri_no;
        int         target;
        int         kind;
        int         n;
        mode_cycle = '{MODE_TWELVE, MODE_THREE, MODE_ONE, MODE_UNDEF};
        mode = mode_cycle[seg % 4];
        addr = (seg == 1) ? 4'd0 : (seg == 2) ? 4'd15 : 4'($urandom_range(0, 15));
        apply_settings(addr, mode);
        case (seg / 4)
            0: begin
                sender_idle_pct   = 38;
                receiver_idle_pct = 68;
            end
            1: begin
                sender_idle_pct   = 68;
                receiver_idle_pct = 38;
            end
            default: begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
        target = gen_effective + ((mode == MODE_UNDEF) ? 30 : 150);
        while (gen_effective < target) begin
            kind   = $urandom_range(0, 99);
            tri_no = 4'($urandom_range(0, 15));
            if (kind < 12) begin
                // calibration sweep of a whole triangle
                for (int t = 0; t < TAXELS; t++)
                    queue_reading(OP_CALIBRATE, tri_no, 4'(t), 16'($urandom));
            end else if (kind < 72) begin
                // scan of the active taxels in frame order
                n = active_taxels(gen_mode);
                if (n == 0) begin
                    for (int t = 0; t < 3; t++)
                        queue_reading(OP_MEASURE, tri_no, 4'($urandom_range(0, 15)),
                                      16'($urandom));
                end else begin
                    for (int t = 0; t < n; t++)
                        queue_reading(OP_MEASURE, tri_no, 4'(t), near_raw(tri_no, 4'(t)));
                end
            end else begin
                n = $urandom_range(0, 15);
                queue_reading(1'($urandom_range(0, 1)), tri_no, 4'(n),
                              near_raw(tri_no, 4'(n)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            model_baseline[i] = '0;
            gen_baseline[i]   = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct   = 38;
        receiver_idle_pct = 68;

        // Directed part under the reset settings: twelve taxels, board address 15.
        queue_reading(OP_MEASURE,   4'd0, 4'd0, 16'h0000);  // baseline still cleared
        queue_reading(OP_CALIBRATE, 4'd0, 4'd0, 16'h8000);
        queue_reading(OP_MEASURE,   4'd0, 4'd0, 16'h8000);  // read straight after store
        queue_reading(OP_MEASURE,   4'd0, 4'd1, 16'hFFFF);  // far above a zero baseline
        queue_reading(OP_CALIBRATE, 4'd0, 4'd1, 16'h8000);
        queue_reading(OP_MEASURE,   4'd0, 4'd1, 16'h7FD9);  // just short of the top
        queue_reading(OP_MEASURE,   4'd0, 4'd1, 16'h7FD8);  // saturates high
        queue_reading(OP_MEASURE,   4'd0, 4'd1, 16'h83CB);  // just short of the bottom
        queue_reading(OP_MEASURE,   4'd0, 4'd1, 16'h83CC);  // saturates low
        queue_reading(OP_CALIBRATE, 4'd15, 4'd11, 16'hFFFF);
        queue_reading(OP_MEASURE,   4'd15, 4'd11, 16'h0000);
        queue_reading(OP_MEASURE,   4'd15, 4'd11, 16'hFFFF);
        queue_reading(OP_MEASURE,   4'd15, 4'd6, 16'h1234);  // closes the first frame
        queue_reading(OP_MEASURE,   4'd15, 4'd7, 16'h0004);  // opens the second frame
        queue_reading(OP_MEASURE,   4'd3, 4'd12, 16'h5555);  // taxel beyond the store
        queue_reading(OP_CALIBRATE, 4'd3, 4'd15, 16'hFFFF);
        queue_reading(OP_MEASURE,   4'd3, 4'd15, 16'hAAAA);

        apply_settings(4'd0, MODE_THREE);
        queue_reading(OP_MEASURE, 4'd5, 4'd0, 16'h0010);
        queue_reading(OP_MEASURE, 4'd5, 4'd2, 16'h0020);
        queue_reading(OP_MEASURE, 4'd5, 4'd3, 16'h0030);     // beyond the active count

        apply_settings(4'd9, MODE_ONE);
        queue_reading(OP_MEASURE, 4'd9, 4'd0, 16'h0001);
        queue_reading(OP_MEASURE, 4'd9, 4'd1, 16'h0002);

        // The undefined mode measures nothing but still stores baselines.
        apply_settings(4'd6, MODE_UNDEF);
        queue_reading(OP_MEASURE,   4'd9, 4'd0, 16'h0100);
        queue_reading(OP_CALIBRATE, 4'd9, 4'd0, 16'h0100);
        apply_settings(4'd6, MODE_TWELVE);
        queue_reading(OP_MEASURE,   4'd9, 4'd0, 16'h0100);

        for (int seg = 0; seg < SEGMENTS; seg++)
            run_random_segment(seg);
        wait_idle();

        $display("Covered %0d reading words under %0d register settings in all taxel modes,",
                 words_accepted, settings_count);
        $display("with %0d output bytes checked, %0d of them frame headers.",
                 bytes_out, header_count);
        if (mismatches == 0) begin
            $display("taxel_baseline_compress_framer_core_test OK");
        end else begin
            $display("taxel_baseline_compress_framer_core_test NOT OK");
        end
        $finish;
    end

endmodule
